/* hw/rtl/assert_macros.svh */
// Assertion macros shared by the RTL files of the linked list engine.
// No dependencies; taken in by `include where a module checks itself.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every clock edge outside reset.
`define ASSERT_AT(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");

// Consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* hw/rtl/sll_pkg.sv */
// Package for the static linked list engine: field widths, request and
// status codes, and the request/result word structs. No dependencies.
`default_nettype none

package sll_pkg;

    // Default slot count of the store
    localparam int SLOTS_DEF = 1024;

    // Field widths
    localparam int REQ_W  = 2;
    localparam int POS_W  = 11;
    localparam int VAL_W  = 32;
    localparam int STAT_W = 2;
    localparam int LEN_W  = 11;

    // Stream word widths (whole bytes)
    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 16;

    // Request codes
    localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
    localparam logic [REQ_W-1:0] REQ_DELETE = 2'd1;
    localparam logic [REQ_W-1:0] REQ_SEARCH = 2'd2;

    // Status codes
    localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
    localparam logic [STAT_W-1:0] ST_BAD_POS = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL    = 2'd2;

    typedef struct packed {
        logic [REQ_W-1:0]        req_type;
        logic [POS_W-1:0]        position;
        logic signed [VAL_W-1:0] value;
    } t_req;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic              found;
        logic [LEN_W-1:0]  length;
    } t_res;

endpackage

`default_nettype wire

/* hw/rtl/sll_core.sv */
// Sequencer and slot stores of the linked list engine: link and data
// memories, list/free heads and the chain walker. Depends on sll_pkg.
`default_nettype none

`include "assert_macros.svh"

module sll_core
    import sll_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_req_valid,
    output logic      o_req_ready,
    input  wire t_req i_req,
    output logic      o_res_valid,
    input  wire logic i_res_ready,
    output t_res      o_res
);

    // Link width holds a slot index or the null link (SLOTS)
    localparam int LW    = $clog2(SLOTS + 1);
    localparam int AW    = $clog2(SLOTS);
    localparam int CMP_W = POS_W + LW;
    localparam logic [LW-1:0] NULL_LINK = LW'(SLOTS);

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_INS_FREE,
        S_WALK,
        S_INS_SPLICE,
        S_DEL_HEAD,
        S_DEL_NEXT,
        S_DEL_FREE,
        S_SRCH,
        S_DONE
    } t_state;

    // Slot stores
    logic [LW-1:0]    link_mem [SLOTS];
    logic [VAL_W-1:0] data_mem [SLOTS];

    // Control state
    t_state           r_state, n_state;
    t_req             r_req, n_req;
    logic [LW-1:0]    r_count, n_count;
    logic [LW-1:0]    r_free_head, n_free_head;
    logic [LW-1:0]    r_list_head, n_list_head;
    logic [LW-1:0]    r_hwm, n_hwm;
    logic [LW-1:0]    r_p, n_p;
    logic [LW-1:0]    r_q, n_q;
    logic [POS_W-1:0] r_steps, n_steps;
    logic [STAT_W-1:0] r_status, n_status;
    logic             r_found, n_found;

    // Memory read side
    logic [LW-1:0]    r_link_rd;
    logic [VAL_W-1:0] r_data_rd;
    logic [LW-1:0]    r_rd_addr;
    logic             r_rd_virgin;

    // Memory controls
    logic             rd_en;
    logic [LW-1:0]    rd_addr;
    logic             link_wr_en;
    logic [LW-1:0]    link_wr_addr;
    logic [LW-1:0]    link_wr_data;
    logic             data_wr_en;

    logic [LW-1:0]    link_q;
    logic [CMP_W-1:0] pos_ext;
    logic [CMP_W-1:0] cnt_ext;
    logic             pos_zero;
    logic             pos_one;

    // Slots at or above the high-water mark were never written: they link to i+1
    assign link_q = r_rd_virgin ? (r_rd_addr + LW'(1)) : r_link_rd;

    assign pos_ext  = CMP_W'(r_req.position);
    assign cnt_ext  = CMP_W'(r_count);
    assign pos_zero = (r_req.position == '0);
    assign pos_one  = (r_req.position == POS_W'(1));

    // Next state and memory control
    always_comb begin
        n_state      = r_state;
        n_req        = r_req;
        n_count      = r_count;
        n_free_head  = r_free_head;
        n_list_head  = r_list_head;
        n_hwm        = r_hwm;
        n_p          = r_p;
        n_q          = r_q;
        n_steps      = r_steps;
        n_status     = r_status;
        n_found      = r_found;
        rd_en        = 1'b0;
        rd_addr      = r_list_head;
        link_wr_en   = 1'b0;
        link_wr_addr = r_q;
        link_wr_data = r_list_head;
        data_wr_en   = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    n_req   = i_req;
                    n_state = S_CHECK;
                end
            end

            S_CHECK: begin
                n_status = ST_OK;
                n_found  = 1'b0;
                case (r_req.req_type)
                    REQ_INSERT: begin
                        if (pos_zero || (pos_ext > cnt_ext + CMP_W'(1))) begin
                            n_status = ST_BAD_POS;
                            n_state  = S_DONE;
                        end else if (r_free_head == NULL_LINK) begin
                            n_status = ST_FULL;
                            n_state  = S_DONE;
                        end else begin
                            rd_en   = 1'b1;
                            rd_addr = r_free_head;
                            n_q     = r_free_head;
                            n_state = S_INS_FREE;
                        end
                    end
                    REQ_DELETE: begin
                        if (pos_zero || (pos_ext > cnt_ext)) begin
                            n_status = ST_BAD_POS;
                            n_state  = S_DONE;
                        end else if (pos_one) begin
                            rd_en   = 1'b1;
                            rd_addr = r_list_head;
                            n_q     = r_list_head;
                            n_state = S_DEL_HEAD;
                        end else begin
                            rd_en   = 1'b1;
                            rd_addr = r_list_head;
                            n_p     = r_list_head;
                            n_steps = r_req.position - POS_W'(2);
                            n_state = S_WALK;
                        end
                    end
                    REQ_SEARCH: begin
                        if (r_list_head == NULL_LINK) begin
                            n_state = S_DONE;
                        end else begin
                            rd_en   = 1'b1;
                            rd_addr = r_list_head;
                            n_state = S_SRCH;
                        end
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end

            // Pop the free chain, store the value
            S_INS_FREE: begin
                n_free_head = link_q;
                data_wr_en  = 1'b1;
                if (r_rd_virgin) begin
                    n_hwm = r_hwm + LW'(1);
                end
                if (pos_one) begin
                    link_wr_en   = 1'b1;
                    link_wr_addr = r_q;
                    link_wr_data = r_list_head;
                    n_list_head  = r_q;
                    n_count      = r_count + LW'(1);
                    n_status     = ST_OK;
                    n_state      = S_DONE;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = r_list_head;
                    n_p     = r_list_head;
                    n_steps = r_req.position - POS_W'(2);
                    n_state = S_WALK;
                end
            end

            // One link per cycle; at the end r_p is the target and link_q its successor
            S_WALK: begin
                if (r_steps == '0) begin
                    if (r_req.req_type == REQ_INSERT) begin
                        link_wr_en   = 1'b1;
                        link_wr_addr = r_q;
                        link_wr_data = link_q;
                        n_state      = S_INS_SPLICE;
                    end else begin
                        rd_en   = 1'b1;
                        rd_addr = link_q;
                        n_q     = link_q;
                        n_state = S_DEL_NEXT;
                    end
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = link_q;
                    n_p     = link_q;
                    n_steps = r_steps - POS_W'(1);
                end
            end

            S_INS_SPLICE: begin
                link_wr_en   = 1'b1;
                link_wr_addr = r_p;
                link_wr_data = r_q;
                n_count      = r_count + LW'(1);
                n_status     = ST_OK;
                n_state      = S_DONE;
            end

            // Unlink the head and push it on the free chain
            S_DEL_HEAD: begin
                n_list_head  = link_q;
                link_wr_en   = 1'b1;
                link_wr_addr = r_q;
                link_wr_data = r_free_head;
                n_free_head  = r_q;
                n_count      = r_count - LW'(1);
                n_status     = ST_OK;
                n_state      = S_DONE;
            end

            S_DEL_NEXT: begin
                link_wr_en   = 1'b1;
                link_wr_addr = r_p;
                link_wr_data = link_q;
                n_state      = S_DEL_FREE;
            end

            S_DEL_FREE: begin
                link_wr_en   = 1'b1;
                link_wr_addr = r_q;
                link_wr_data = r_free_head;
                n_free_head  = r_q;
                n_count      = r_count - LW'(1);
                n_status     = ST_OK;
                n_state      = S_DONE;
            end

            // Compare one slot per cycle against the key
            S_SRCH: begin
                if (r_data_rd == VAL_W'($unsigned(r_req.value))) begin
                    n_found = 1'b1;
                    n_state = S_DONE;
                end else if (link_q == NULL_LINK) begin
                    n_state = S_DONE;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = link_q;
                end
            end

            S_DONE: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_free_head <= '0;
            r_list_head <= NULL_LINK;
            r_hwm       <= '0;
            r_status    <= ST_OK;
            r_found     <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_free_head <= n_free_head;
            r_list_head <= n_list_head;
            r_hwm       <= n_hwm;
            r_status    <= n_status;
            r_found     <= n_found;
        end
        r_req   <= n_req;
        r_p     <= n_p;
        r_q     <= n_q;
        r_steps <= n_steps;
    end

    // Link and data memories, registered reads
    always_ff @(posedge i_clk) begin
        if (link_wr_en) begin
            link_mem[link_wr_addr[AW-1:0]] <= link_wr_data;
        end
        if (data_wr_en) begin
            data_mem[r_q[AW-1:0]] <= VAL_W'($unsigned(r_req.value));
        end
        if (rd_en) begin
            r_link_rd   <= link_mem[rd_addr[AW-1:0]];
            r_data_rd   <= data_mem[rd_addr[AW-1:0]];
            r_rd_addr   <= rd_addr;
            r_rd_virgin <= (rd_addr >= r_hwm);
        end
    end

    assign o_req_ready  = (r_state == S_IDLE);
    assign o_res_valid  = (r_state == S_DONE);
    assign o_res.status = r_status;
    assign o_res.found  = r_found;
    assign o_res.length = LEN_W'(r_count);

    `ASSERT_AT(a_count_range, i_clk, i_rst_n, r_count <= NULL_LINK)
    `ASSERT_AT(a_hwm_range, i_clk, i_rst_n, r_hwm <= NULL_LINK)
    `ASSERT_AT(a_idle_free_full, i_clk, i_rst_n,
        (r_state != S_IDLE) || ((r_free_head == NULL_LINK) == (r_count == NULL_LINK)))
    `ASSERT_AT(a_search_not_null, i_clk, i_rst_n,
        (r_state != S_SRCH) || (r_rd_addr != NULL_LINK))

endmodule

`default_nettype wire

/* hw/rtl/static_linked_list_engine.sv */
// Top level of the static linked list engine: stream ports, word
// unpacking and the result output register. Depends on sll_pkg, sll_core.
//
//  channel   dir  tdata (low bit up)             tuser
//  s_axis    in   position[10:0], value[42:11]   req_type[1:0]
//  m_axis    out  found[0], length[11:1]         status[1:0]
//
// Steps: accept, a check, then one link per cycle followed through the
// single link-memory read port; insert and delete walk to the position,
// search walks until a match or the list end, and the result then goes to
// the output register.
// Reset is synchronous; the link store is not swept, a high-water mark
// stands in for its initial i+1 chain.
// s_axis_tready is low while a request is in work; a stalled result waits
// in the output register while the next request runs.
`default_nettype none

`include "assert_macros.svh"

module static_linked_list_engine
    import sll_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    input  wire logic [S_TDATA_W-1:0] s_axis_tdata,  // position, value
    input  wire logic [REQ_W-1:0]     s_axis_tuser,  // req_type
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    output logic [M_TDATA_W-1:0]      m_axis_tdata,  // found, length
    output logic [STAT_W-1:0]         m_axis_tuser   // status
);

    t_req req;
    t_res core_res;
    logic core_res_valid;
    logic core_res_ready;
    logic core_req_ready;

    logic r_m_valid;
    t_res r_m_res;

    // Unpack the input word
    assign req.req_type = s_axis_tuser;
    assign req.position = s_axis_tdata[POS_W-1:0];
    assign req.value    = $signed(s_axis_tdata[POS_W+VAL_W-1:POS_W]);

    sll_core #(
        .SLOTS (SLOTS)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (s_axis_tvalid),
        .o_req_ready (core_req_ready),
        .i_req       (req),
        .o_res_valid (core_res_valid),
        .i_res_ready (core_res_ready),
        .o_res       (core_res)
    );

    assign s_axis_tready = core_req_ready;

    // Output register
    assign core_res_ready = !r_m_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (core_res_ready) begin
            r_m_valid <= core_res_valid;
        end
        if (core_res_ready && core_res_valid) begin
            r_m_res <= core_res;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tuser  = r_m_res.status;
    assign m_axis_tdata  = M_TDATA_W'({r_m_res.length, r_m_res.found});

    `ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n,
        s_axis_tvalid && s_axis_tready, !s_axis_tready)

endmodule

`default_nettype wire
